// ===== hw/rtl/c64fc_pkg.sv =====
package c64fc_pkg;

    // Cartridge RAM size, the window offset width of the bus and the freeze write count
    localparam int unsigned RAM_BYTES     = 8192;
    localparam int unsigned OFF_W         = 13;
    localparam int unsigned WRITES_TO_MAP = 3;

    // I/O area two mirrors the last page of the low window
    localparam logic [OFF_W-1:0] LAST_PAGE = 13'h1f00;

    // Control byte bits
    localparam int unsigned CR_RELEASE_BIT = 6;
    localparam int unsigned CR_RAMEN_BIT   = 5;
    localparam int unsigned CR_BANK_HI     = 4;
    localparam int unsigned CR_BANK_LO     = 3;
    localparam int unsigned CR_DISABLE_BIT = 2;
    localparam int unsigned CR_EXROM_BIT   = 1;
    localparam int unsigned CR_GAME_BIT    = 0;

    // Control byte loaded at the end of the freeze sequence: bank 0 ROM, ultimax
    localparam logic [7:0] CR_ULTIMAX = 8'b0000_0011;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_IO1  = 2'd1,
        OP_IO2  = 2'd2,
        OP_ROML = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DRV_NONE = 2'd0,
        DRV_RAM  = 2'd1,
        DRV_ROM  = 2'd2
    } drive_t;

    typedef struct packed {
        logic       release_lines;
        logic [1:0] bank;
        logic       ram_mapped;
        logic       disabled;
        logic       exrom_level;
        logic       game_level;
    } ctrl_t;

    function automatic ctrl_t decode_ctrl(input logic [7:0] cr);
        ctrl_t c;
        c.release_lines = cr[CR_RELEASE_BIT];
        c.bank          = cr[CR_BANK_HI:CR_BANK_LO];
        c.ram_mapped    = cr[CR_RAMEN_BIT];
        c.disabled      = cr[CR_DISABLE_BIT];
        c.exrom_level   = ~cr[CR_EXROM_BIT];
        c.game_level    = cr[CR_GAME_BIT];
        return c;
    endfunction

endpackage

// ===== hw/rtl/c64_freeze_cartridge_banking_core.sv =====
// Channel  Dir  tdata (low bit up)                          tuser
// s_*      in   address[12:0] write_data[20:13]             op[1:0] is_read[2]
//               freeze_button[21] (pad to 24)
// m_*      out  ram_data[7:0] rom_address[22:8]             drive_source[1:0]
//               high_rom_bank[24:23] nmi[25] irq[26]
//               exrom[27] game[28] led[29] cart_en[30] (pad)
//
// One beat per cycle sustained while m_tready is high; a beat's result reaches m_*
// through the input/RAM read register, then the result register.
// After reset the cartridge RAM is zeroed one byte per cycle: s_tready stays
// low until every byte of RAM_BYTES is cleared.
// A stalled m_* holds the result; the input stage keeps one beat and then
// drops s_tready until the result register drains.
module c64_freeze_cartridge_banking_core #(
    parameter int unsigned WRITES_TO_MAP = c64fc_pkg::WRITES_TO_MAP
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address, write_data, freeze_button
    input  logic [2:0]  s_tuser,   // op, is_read
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // ram_data, rom_address, high_rom_bank, line levels
    output logic [1:0]  m_tuser    // drive_source
);

    localparam int unsigned OW = c64fc_pkg::OFF_W;
    localparam logic [1:0] RELOAD = 2'(WRITES_TO_MAP);
    localparam logic [OW-1:0] CLR_LAST = OW'(c64fc_pkg::RAM_BYTES - 1);

    // Input beat decode
    logic               in_accept;
    c64fc_pkg::op_t     in_op;
    logic [OW-1:0]      in_off;

    assign in_accept = s_tvalid & s_tready;
    assign in_op     = c64fc_pkg::op_t'(s_tuser[1:0]);
    // area two only uses the low 8 address bits, on the last page
    assign in_off    = (in_op == c64fc_pkg::OP_IO2)
                       ? (c64fc_pkg::LAST_PAGE | {5'b0, s_tdata[7:0]})
                       : s_tdata[OW-1:0];

    // Input stage
    logic               s1_valid_reg;
    c64fc_pkg::op_t     s1_op_reg;
    logic [OW-1:0]      s1_off_reg;
    logic               s1_rd_reg;
    logic [7:0]         s1_wdata_reg;
    logic               s1_frz_reg;
    logic               s1_adv;

    // RAM and its clearing pass
    logic [7:0]         ram_mem [c64fc_pkg::RAM_BYTES];
    logic [7:0]         rd_q_reg;
    logic               byp_hit_reg;
    logic [7:0]         byp_data_reg;
    logic               clr_busy_reg;
    logic [OW-1:0]      clr_cnt_reg;
    logic               mem_we;
    logic [OW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;

    // Cartridge state
    logic [1:0]         bank_reg, bank_next;
    logic               ram_map_reg, ram_map_next;
    logic               dis_reg, dis_next;
    logic               exrom_reg, exrom_next;
    logic               game_reg, game_next;
    logic               nmi_reg, nmi_next;
    logic               irq_reg, irq_next;
    logic               led_reg, led_next;
    logic               pend_reg, pend_next;
    logic [1:0]         cnt_reg, cnt_next;

    // Result
    logic               out_valid_reg;
    logic [31:0]        out_tdata_reg;
    logic [1:0]         out_tuser_reg;
    c64fc_pkg::drive_t  drive;
    logic [7:0]         ram_out;
    logic [14:0]        rom_out;
    logic [7:0]         ram_byte;
    logic               ram_we;
    c64fc_pkg::ctrl_t   ctl_user;
    c64fc_pkg::ctrl_t   ctl_frz;

    assign s1_adv   = s1_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~clr_busy_reg & (~s1_valid_reg | s1_adv);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

    assign ctl_user = c64fc_pkg::decode_ctrl(s1_wdata_reg);
    assign ctl_frz  = c64fc_pkg::decode_ctrl(c64fc_pkg::CR_ULTIMAX);
    // a write from the beat ahead lands after this beat's RAM read
    assign ram_byte = byp_hit_reg ? byp_data_reg : rd_q_reg;

    assign mem_we    = clr_busy_reg | (s1_adv & ram_we);
    assign mem_waddr = clr_busy_reg ? clr_cnt_reg : s1_off_reg;
    assign mem_wdata = clr_busy_reg ? 8'h00 : s1_wdata_reg;

    // Order: button arms, bus access, then the freeze sequence
    always_comb
    begin
        bank_next    = bank_reg;
        ram_map_next = ram_map_reg;
        dis_next     = dis_reg;
        exrom_next   = exrom_reg;
        game_next    = game_reg;
        nmi_next     = nmi_reg;
        irq_next     = irq_reg;
        led_next     = led_reg;
        pend_next    = pend_reg | s1_frz_reg;
        cnt_next     = cnt_reg;
        drive        = c64fc_pkg::DRV_NONE;
        ram_out      = 8'h00;
        rom_out      = 15'h0000;
        ram_we       = 1'b0;

        if (!dis_reg)
        begin
            if (s1_op_reg == c64fc_pkg::OP_IO1)
            begin
                if (!s1_rd_reg)
                begin
                    bank_next    = ctl_user.bank;
                    ram_map_next = ctl_user.ram_mapped;
                    dis_next     = ctl_user.disabled;
                    exrom_next   = ctl_user.exrom_level;
                    game_next    = ctl_user.game_level;
                    if (ctl_user.release_lines)
                    begin
                        nmi_next = 1'b0;
                        irq_next = 1'b0;
                    end
                    if (ctl_user.disabled)
                    begin
                        led_next = 1'b0;
                    end
                end
            end
            else if (s1_op_reg inside {c64fc_pkg::OP_IO2, c64fc_pkg::OP_ROML})
            begin
                if (s1_rd_reg)
                begin
                    if (ram_map_reg)
                    begin
                        drive   = c64fc_pkg::DRV_RAM;
                        ram_out = ram_byte;
                    end
                    else
                    begin
                        drive   = c64fc_pkg::DRV_ROM;
                        rom_out = {bank_reg, s1_off_reg};
                    end
                end
                else
                begin
                    ram_we = ram_map_reg;
                end
            end
        end

        if (pend_next)
        begin
            if (s1_rd_reg)
            begin
                nmi_next  = 1'b1;
                irq_next  = 1'b1;
                led_next  = 1'b1;
                pend_next = 1'b0;
                cnt_next  = RELOAD;
            end
        end
        else if (cnt_reg != 2'd0)
        begin
            if (s1_rd_reg)
            begin
                cnt_next = RELOAD;
            end
            else
            begin
                cnt_next = cnt_reg - 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    bank_next    = ctl_frz.bank;
                    ram_map_next = ctl_frz.ram_mapped;
                    dis_next     = ctl_frz.disabled;
                    exrom_next   = ctl_frz.exrom_level;
                    game_next    = ctl_frz.game_level;
                end
            end
        end
    end

    // RAM: one write port, one registered read at the incoming beat's offset
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ram_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            rd_q_reg <= ram_mem[in_off];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byp_hit_reg  <= s1_adv & ram_we & (s1_off_reg == in_off);
            byp_data_reg <= s1_wdata_reg;
            s1_op_reg    <= in_op;
            s1_off_reg   <= in_off;
            s1_rd_reg    <= s_tuser[2];
            s1_wdata_reg <= s_tdata[20:13];
            s1_frz_reg   <= s_tdata[21];
        end
        if (s1_adv)
        begin
            out_tuser_reg <= drive;
            out_tdata_reg <= {1'b0, ~dis_next, led_next, game_next, exrom_next,
                              irq_next, nmi_next, bank_next, rom_out, ram_out};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bank_reg      <= 2'd0;
            ram_map_reg   <= 1'b0;
            dis_reg       <= 1'b0;
            exrom_reg     <= 1'b1;
            game_reg      <= 1'b0;
            nmi_reg       <= 1'b0;
            irq_reg       <= 1'b0;
            led_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                bank_reg    <= bank_next;
                ram_map_reg <= ram_map_next;
                dis_reg     <= dis_next;
                exrom_reg   <= exrom_next;
                game_reg    <= game_next;
                nmi_reg     <= nmi_next;
                irq_reg     <= irq_next;
                led_reg     <= led_next;
                pend_reg    <= pend_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

endmodule
